// ----- sv/kre_pkg.sv -----
// ----------------------------------------------------------------------------
// kre_pkg: keyboard report to key events, shared types and constants
// Report and event payloads, the job passed from front to back, and the
// scancode translation ROM.
// ----------------------------------------------------------------------------
package kre_pkg;

	localparam int MAX_SLOTS = 6;
	localparam int MAX_MODS = 8;
	localparam int MOD_IDX_W = 3;
	localparam int EV_BITS = 2 * MAX_SLOTS;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] MOD_BASE = 8'd224;
	localparam logic [7:0] NONE_LIMIT = 8'd3;
	localparam logic [31:0] EXPECTED_FUNCTION_RESET = 32'd1;

	typedef struct packed {
		logic [31:0] function_code;
		logic [7:0]  modifiers;
		logic [7:0]  key0;
		logic [7:0]  key1;
		logic [7:0]  key2;
		logic [7:0]  key3;
		logic [7:0]  key4;
		logic [7:0]  key5;
	} kre_report_t;

	typedef struct packed {
		logic [7:0] key_code;
		logic [7:0] scancode;
		logic       pressed;
		logic       unknown;
		logic       last;
	} kre_event_t;

	typedef logic [MAX_SLOTS-1:0][7:0] kre_keys_t;

	// ev_mask bit 2i: release of old slot i, bit 2i+1: press of new slot i
	typedef struct packed {
		logic [7:0]         modifiers;
		kre_keys_t          old_keys;
		kre_keys_t          new_keys;
		logic [EV_BITS-1:0] ev_mask;
	} kre_job_t;

	function automatic logic [7:0] key_rom(input logic [7:0] sc);
		logic [7:0] f;
		case (sc)
			8'd4: f = 8'd30;    8'd5: f = 8'd48;    8'd6: f = 8'd46;    8'd7: f = 8'd32;
			8'd8: f = 8'd18;    8'd9: f = 8'd33;    8'd10: f = 8'd34;   8'd11: f = 8'd35;
			8'd12: f = 8'd23;   8'd13: f = 8'd36;   8'd14: f = 8'd37;   8'd15: f = 8'd38;
			8'd16: f = 8'd50;   8'd17: f = 8'd49;   8'd18: f = 8'd24;   8'd19: f = 8'd25;
			8'd20: f = 8'd16;   8'd21: f = 8'd19;   8'd22: f = 8'd31;   8'd23: f = 8'd20;
			8'd24: f = 8'd22;   8'd25: f = 8'd47;   8'd26: f = 8'd17;   8'd27: f = 8'd45;
			8'd28: f = 8'd21;   8'd29: f = 8'd44;
			8'd30: f = 8'd2;    8'd31: f = 8'd3;    8'd32: f = 8'd4;    8'd33: f = 8'd5;
			8'd34: f = 8'd6;    8'd35: f = 8'd7;    8'd36: f = 8'd8;    8'd37: f = 8'd9;
			8'd38: f = 8'd10;   8'd39: f = 8'd11;
			8'd40: f = 8'd28;   8'd41: f = 8'd1;    8'd42: f = 8'd14;   8'd43: f = 8'd15;
			8'd44: f = 8'd57;   8'd45: f = 8'd12;   8'd46: f = 8'd13;   8'd47: f = 8'd26;
			8'd48: f = 8'd27;   8'd49: f = 8'd43;
			8'd50: f = 8'd84;   8'd51: f = 8'd39;   8'd52: f = 8'd40;   8'd53: f = 8'd41;
			8'd54: f = 8'd51;   8'd55: f = 8'd52;   8'd56: f = 8'd53;   8'd57: f = 8'd58;
			8'd58: f = 8'd59;   8'd59: f = 8'd60;   8'd60: f = 8'd61;   8'd61: f = 8'd62;
			8'd62: f = 8'd63;   8'd63: f = 8'd64;   8'd64: f = 8'd65;   8'd65: f = 8'd66;
			8'd66: f = 8'd67;   8'd67: f = 8'd68;   8'd68: f = 8'd87;   8'd69: f = 8'd88;
			8'd70: f = 8'd99;   8'd71: f = 8'd70;   8'd72: f = 8'd119;  8'd73: f = 8'd110;
			8'd74: f = 8'd102;  8'd75: f = 8'd104;  8'd76: f = 8'd111;  8'd77: f = 8'd107;
			8'd78: f = 8'd109;  8'd79: f = 8'd106;  8'd80: f = 8'd105;  8'd81: f = 8'd108;
			8'd82: f = 8'd103;
			8'd83: f = 8'd69;   8'd84: f = 8'd98;   8'd85: f = 8'd55;   8'd86: f = 8'd74;
			8'd87: f = 8'd78;   8'd88: f = 8'd96;   8'd89: f = 8'd79;   8'd90: f = 8'd80;
			8'd91: f = 8'd81;   8'd92: f = 8'd75;   8'd93: f = 8'd76;   8'd94: f = 8'd77;
			8'd95: f = 8'd71;   8'd96: f = 8'd72;   8'd97: f = 8'd73;   8'd98: f = 8'd82;
			8'd99: f = 8'd83;
			8'd100: f = 8'd86;  8'd101: f = 8'd127; 8'd102: f = 8'd116; 8'd103: f = 8'd117;
			8'd104: f = 8'd85;  8'd105: f = 8'd89;  8'd106: f = 8'd90;  8'd107: f = 8'd91;
			8'd108: f = 8'd92;  8'd109: f = 8'd93;  8'd110: f = 8'd94;  8'd111: f = 8'd95;
			8'd112: f = 8'd120; 8'd113: f = 8'd121; 8'd114: f = 8'd122; 8'd115: f = 8'd123;
			8'd116: f = 8'd134; 8'd117: f = 8'd138; 8'd118: f = 8'd130; 8'd119: f = 8'd132;
			8'd120: f = 8'd128; 8'd121: f = 8'd129; 8'd122: f = 8'd131; 8'd123: f = 8'd137;
			8'd124: f = 8'd133; 8'd125: f = 8'd135; 8'd126: f = 8'd136; 8'd127: f = 8'd113;
			8'd128: f = 8'd115; 8'd129: f = 8'd114;
			8'd133: f = 8'd124;
			8'd135: f = 8'd181; 8'd136: f = 8'd182; 8'd137: f = 8'd183; 8'd138: f = 8'd184;
			8'd139: f = 8'd185; 8'd140: f = 8'd186; 8'd141: f = 8'd187; 8'd142: f = 8'd188;
			8'd143: f = 8'd189; 8'd144: f = 8'd190; 8'd145: f = 8'd191; 8'd146: f = 8'd192;
			8'd147: f = 8'd193; 8'd148: f = 8'd194; 8'd149: f = 8'd195; 8'd150: f = 8'd196;
			8'd151: f = 8'd197; 8'd152: f = 8'd198;
			8'd224: f = 8'd29;  8'd225: f = 8'd42;  8'd226: f = 8'd56;  8'd227: f = 8'd125;
			8'd228: f = 8'd97;  8'd229: f = 8'd54;  8'd230: f = 8'd100; 8'd231: f = 8'd126;
			8'd232: f = 8'd164; 8'd233: f = 8'd166; 8'd234: f = 8'd165; 8'd235: f = 8'd163;
			8'd236: f = 8'd161; 8'd237: f = 8'd115; 8'd238: f = 8'd114; 8'd239: f = 8'd113;
			8'd240: f = 8'd150; 8'd241: f = 8'd158; 8'd242: f = 8'd159; 8'd243: f = 8'd128;
			8'd244: f = 8'd136; 8'd245: f = 8'd177; 8'd246: f = 8'd178; 8'd247: f = 8'd176;
			8'd248: f = 8'd142; 8'd249: f = 8'd152; 8'd250: f = 8'd173; 8'd251: f = 8'd140;
			default: f = 8'd0;
		endcase
		return f;
	endfunction

endpackage

// ----- sv/kre_front.sv -----
// ----------------------------------------------------------------------------
// kre_front: report intake and classification
// Holds the expected function code and the stored keys, filters reports and
// works out which release and press events each report causes.
// ----------------------------------------------------------------------------
module kre_front import kre_pkg::*; #(
	parameter int KEY_SLOTS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        rpt_valid,
	input  kre_report_t rpt,
	output logic        rpt_stall,
	input  logic        q_full,
	output logic        push,
	output kre_job_t    job
);

	logic [31:0] exp_func_q;
	kre_keys_t   prev_keys_q;
	kre_keys_t   fresh;
	logic        match;

	assign fresh = {rpt.key5, rpt.key4, rpt.key3, rpt.key2, rpt.key1, rpt.key0};
	assign match = (rpt.function_code == exp_func_q);
	assign rpt_stall = q_full;
	assign push = rpt_valid && !rpt_stall && match;

	always_comb begin
		logic in_new, in_old;
		job.modifiers = rpt.modifiers;
		job.old_keys = prev_keys_q;
		job.new_keys = fresh;
		job.ev_mask = '0;
		for (int i = 0; i < KEY_SLOTS; i++) begin
			in_new = 1'b0;
			in_old = 1'b0;
			for (int j = 0; j < KEY_SLOTS; j++) begin
				if (fresh[j] == prev_keys_q[i]) in_new = 1'b1;
				if (prev_keys_q[j] == fresh[i]) in_old = 1'b1;
			end
			job.ev_mask[2*i] = (prev_keys_q[i] > NONE_LIMIT) && !in_new;
			job.ev_mask[2*i+1] = (fresh[i] > NONE_LIMIT) && !in_old;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_func_q <= EXPECTED_FUNCTION_RESET;
			prev_keys_q <= '0;
		end else begin
			if (cfg_we) exp_func_q <= cfg_wdata;
			if (push) prev_keys_q <= fresh;
		end
	end

endmodule

// ----- sv/kre_queue.sv -----
// ----------------------------------------------------------------------------
// kre_queue: job queue
// Short FIFO between the front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module kre_queue import kre_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  kre_job_t wr_job,
	input  logic     pop,
	output logic     full,
	output logic     head_valid,
	output kre_job_t head
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	kre_job_t        mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full = (count_q == CW'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/kre_back.sv -----
// ----------------------------------------------------------------------------
// kre_back: event sequencer
// Walks one job at a time: modifier events first, then pending release and
// press events in slot order, one event per cycle into the output register while evt_stall is low.
// ----------------------------------------------------------------------------
module kre_back import kre_pkg::*; #(
	parameter int MODIFIER_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  kre_job_t   head,
	output logic       pop,
	output logic       evt_valid,
	input  logic       evt_stall,
	output kre_event_t evt
);

	localparam logic [MOD_IDX_W-1:0] MOD_LAST = MOD_IDX_W'(MODIFIER_COUNT - 1);

	logic                 busy_q;
	logic                 mod_phase_q;
	logic [MOD_IDX_W-1:0] mod_idx_q;
	logic [7:0]           mods_q;
	kre_keys_t            old_q;
	kre_keys_t            new_q;
	logic [EV_BITS-1:0]   mask_q;

	logic                 evt_valid_q;
	kre_event_t           evt_q;

	logic [EV_BITS-1:0]   pick;
	logic [EV_BITS-1:0]   rest;
	logic [7:0]           sc;
	logic                 prs;
	logic                 is_last;
	logic                 out_free;
	logic                 fire;
	kre_event_t           ev;

	assign pick = mask_q & (~mask_q + 1'b1);
	assign rest = mask_q & ~pick;

	always_comb begin
		sc = '0;
		prs = 1'b0;
		is_last = 1'b0;
		if (mod_phase_q) begin
			sc = MOD_BASE + {{(8 - MOD_IDX_W){1'b0}}, mod_idx_q};
			prs = mods_q[mod_idx_q];
			is_last = (mod_idx_q == MOD_LAST) && (mask_q == '0);
		end else begin
			for (int k = 0; k < EV_BITS; k++) begin
				if (pick[k]) begin
					sc = (k % 2 == 1) ? new_q[k/2] : old_q[k/2];
					prs = (k % 2 == 1);
				end
			end
			is_last = (rest == '0);
		end
		ev.key_code = key_rom(sc);
		ev.scancode = sc;
		ev.pressed = prs;
		ev.unknown = (ev.key_code == 8'd0);
		ev.last = is_last;
	end

	assign out_free = !evt_valid_q || !evt_stall;
	assign fire = busy_q && out_free;
	assign pop = head_valid && (!busy_q || (fire && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			mod_phase_q <= 1'b0;
			mod_idx_q <= '0;
			mask_q <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			mod_phase_q <= 1'b1;
			mod_idx_q <= '0;
			mask_q <= head.ev_mask;
		end else if (fire) begin
			if (is_last) begin
				busy_q <= 1'b0;
				mod_phase_q <= 1'b0;
			end else if (mod_phase_q) begin
				if (mod_idx_q == MOD_LAST) mod_phase_q <= 1'b0;
				else mod_idx_q <= mod_idx_q + 1'b1;
			end else begin
				mask_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mods_q <= head.modifiers;
			old_q <= head.old_keys;
			new_q <= head.new_keys;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (out_free) begin
			evt_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) evt_q <= ev;
	end

	assign evt_valid = evt_valid_q;
	assign evt = evt_q;

`ifndef NO_ASSERTIONS
	a_phase_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mod_phase_q |-> busy_q)
		else $error("modifier phase while idle");
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !mod_phase_q |-> mask_q != '0)
		else $error("busy with no pending events");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_last && !head_valid |=> !busy_q)
		else $error("sequencer did not go idle after last item");
	a_load_mod: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> mod_phase_q && mod_idx_q == '0)
		else $error("job load did not start modifier events");
`endif

endmodule

// ----- sv/keyboard_report_to_key_events_core.sv -----
// ----------------------------------------------------------------------------
// keyboard_report_to_key_events_core: keyboard report to key event stream
// Filters reports by function code, diffs keys against the last report and
// emits modifier, release and press events translated through the key ROM.
// ----------------------------------------------------------------------------
// Path: the first event of a report passes through the job queue, the sequencer state and the output register.
// Throughput: one event per cycle from the sequencer while evt_stall is low; a report
//   yields MODIFIER_COUNT + releases + presses events (8 to 20 at defaults).
// A two-entry job queue lets reports be taken while events drain.
// Reset: expected function code to 1, stored keys to zero, queue empty.
module keyboard_report_to_key_events_core import kre_pkg::*; #(
	parameter int KEY_SLOTS = 6,
	parameter int MODIFIER_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        rpt_valid,
	output logic        rpt_stall,
	input  kre_report_t rpt,
	output logic        evt_valid,
	input  logic        evt_stall,
	output kre_event_t  evt
);

	logic     push;
	logic     pop;
	logic     q_full;
	logic     head_valid;
	kre_job_t wr_job;
	kre_job_t head;

	kre_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rpt_valid (rpt_valid),
		.rpt       (rpt),
		.rpt_stall (rpt_stall),
		.q_full    (q_full),
		.push      (push),
		.job       (wr_job)
	);

	kre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_job     (wr_job),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	kre_back #(.MODIFIER_COUNT(MODIFIER_COUNT)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.evt_valid  (evt_valid),
		.evt_stall  (evt_stall),
		.evt        (evt)
	);

endmodule

// ----- verif/keyboard_report_to_key_events_core_tb.sv -----
// ----------------------------------------------------------------------------
// keyboard_report_to_key_events_core_tb: self-checking bench for the core
// Drives keyboard reports under several idle and stall patterns and holds a
// local model of the key diff, modifier events and scancode translation.
// Every event the core emits is compared against the model's queue.
// ----------------------------------------------------------------------------
module keyboard_report_to_key_events_core_tb;
	import kre_pkg::*;

	localparam int SLOT_COUNT = 6;
	localparam int MOD_COUNT = 8;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 5000;

	typedef logic [7:0] slot_keys_t [SLOT_COUNT];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        rpt_valid = 1'b0;
	logic        rpt_stall;
	kre_report_t rpt = '0;
	logic        evt_valid;
	logic        evt_stall = 1'b0;
	kre_event_t  evt;

	keyboard_report_to_key_events_core #(
		.KEY_SLOTS(SLOT_COUNT),
		.MODIFIER_COUNT(MOD_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rpt_valid(rpt_valid),
		.rpt_stall(rpt_stall),
		.rpt(rpt),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt(evt)
	);

	always #10 clk = ~clk;

	logic [7:0]  xlat_rom [256];
	logic [31:0] match_function = 32'd1;
	slot_keys_t  held_keys = '{default: 8'd0};
	slot_keys_t  sent_keys = '{default: 8'd0};
	kre_event_t  key_events_due [$];

	int error_count = 0;
	int events_checked = 0;
	int reports_taken = 0;
	int reports_dropped = 0;
	int cfg_writes = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;

	function automatic void rom_run(input int base, input int codes [$]);
		foreach (codes[j])
			xlat_rom[base + j] = 8'(codes[j]);
	endfunction

	function automatic void load_xlat_rom();
		foreach (xlat_rom[j])
			xlat_rom[j] = 8'd0;
		rom_run(4, '{30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50, 49, 24, 25,
			16, 19, 31, 20, 22, 47, 17, 45, 21, 44});
		rom_run(30, '{2, 3, 4, 5, 6, 7, 8, 9, 10, 11});
		rom_run(40, '{28, 1, 14, 15, 57, 12, 13, 26, 27, 43});
		rom_run(50, '{84, 39, 40, 41, 51, 52, 53, 58});
		rom_run(58, '{59, 60, 61, 62, 63, 64, 65, 66, 67, 68, 87, 88});
		rom_run(70, '{99, 70, 119, 110, 102, 104, 111, 107, 109, 106, 105, 108, 103});
		rom_run(83, '{69, 98, 55, 74, 78, 96, 79, 80, 81, 75, 76, 77, 71, 72, 73,
			82, 83});
		rom_run(100, '{86, 127, 116, 117});
		rom_run(104, '{85, 89, 90, 91, 92, 93, 94, 95});
		rom_run(112, '{120, 121, 122, 123, 134, 138, 130, 132, 128, 129, 131, 137,
			133, 135, 136, 113, 115, 114});
		rom_run(133, '{124});
		rom_run(135, '{181, 182, 183, 184, 185, 186, 187, 188, 189, 190, 191, 192,
			193, 194, 195, 196, 197, 198});
		rom_run(224, '{29, 42, 56, 125, 97, 54, 100, 126});
		rom_run(232, '{164, 166, 165, 163, 161, 115, 114, 113});
		rom_run(240, '{150, 158, 159, 128, 136, 177, 178, 176, 142, 152, 173, 140});
	endfunction

	function automatic bit holds_key(input slot_keys_t set, input logic [7:0] code);
		foreach (set[j])
			if (set[j] == code)
				return 1'b1;
		return 1'b0;
	endfunction

	function automatic kre_event_t key_event(input logic [7:0] sc, input logic down);
		kre_event_t ev;
		ev.key_code = xlat_rom[sc];
		ev.scancode = sc;
		ev.pressed = down;
		ev.unknown = (xlat_rom[sc] == 8'd0);
		ev.last = 1'b0;
		return ev;
	endfunction

	function automatic void predict_key_events(input kre_report_t r);
		slot_keys_t fresh;
		kre_event_t evs [$];
		kre_event_t ev;
		if (r.function_code != match_function) begin
			reports_dropped++;
			return;
		end
		reports_taken++;
		fresh = '{r.key0, r.key1, r.key2, r.key3, r.key4, r.key5};
		for (int i = 0; i < MOD_COUNT; i++)
			evs.push_back(key_event(MOD_BASE + 8'(i), r.modifiers[i]));
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (held_keys[i] > NONE_LIMIT && !holds_key(fresh, held_keys[i]))
				evs.push_back(key_event(held_keys[i], 1'b0));
			if (fresh[i] > NONE_LIMIT && !holds_key(held_keys, fresh[i]))
				evs.push_back(key_event(fresh[i], 1'b1));
		end
		held_keys = fresh;
		foreach (evs[j]) begin
			ev = evs[j];
			ev.last = (j == evs.size() - 1);
			key_events_due.push_back(ev);
		end
	endfunction

	function automatic void report_mismatch(input string what, input kre_event_t want,
		input kre_event_t got);
		error_count++;
		if (error_count <= 10)
			$display("%s: expected code %0d sc %0d pr %0b unk %0b last %0b, got code %0d sc %0d pr %0b unk %0b last %0b",
				what, want.key_code, want.scancode, want.pressed, want.unknown, want.last,
				got.key_code, got.scancode, got.pressed, got.unknown, got.last);
	endfunction

	always @(posedge clk) begin
		if (rpt_valid && !rpt_stall)
			predict_key_events(rpt);
		if ((rpt_valid && !rpt_stall) || (evt_valid && !evt_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk) begin
		kre_event_t want;
		if (evt_valid && !evt_stall) begin
			events_checked++;
			if (key_events_due.size() == 0) begin
				want = '0;
				report_mismatch("event with none pending", want, evt);
			end else begin
				want = key_events_due.pop_front();
				if (evt.key_code !== want.key_code || evt.scancode !== want.scancode ||
				    evt.pressed !== want.pressed || evt.unknown !== want.unknown ||
				    evt.last !== want.last)
					report_mismatch("event mismatch", want, evt);
			end
		end
	end

	// receiver stall; a long hold runs on request from the test sequence
	always @(posedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left = HOLD_CYCLES;
		end
		evt_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
		if (hold_left > 0)
			hold_left--;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("FAILURE");
		$finish;
	end

	function automatic kre_report_t make_report(input logic [31:0] fc, input logic [7:0] mods,
		input logic [7:0] k0, k1, k2, k3, k4, k5);
		kre_report_t r;
		r.function_code = fc;
		r.modifiers = mods;
		r.key0 = k0;
		r.key1 = k1;
		r.key2 = k2;
		r.key3 = k3;
		r.key4 = k4;
		r.key5 = k5;
		return r;
	endfunction

	function automatic kre_report_t random_report();
		kre_report_t r;
		slot_keys_t k;
		int p;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			p = $urandom_range(99);
			if (p < 35)
				k[i] = sent_keys[i];
			else if (p < 55)
				k[i] = sent_keys[$urandom_range(SLOT_COUNT - 1)];
			else if (p < 70)
				k[i] = 8'($urandom_range(3));
			else
				k[i] = 8'($urandom_range(255));
		end
		r = make_report(match_function, 8'($urandom_range(255)), k[0], k[1], k[2], k[3],
			k[4], k[5]);
		p = $urandom_range(99);
		if (p < 8)
			r.function_code = $urandom;
		else if (p < 15)
			r.function_code = match_function ^ (32'd1 << $urandom_range(31));
		if (r.function_code == match_function)
			sent_keys = k;
		return r;
	endfunction

	task automatic send_report(input kre_report_t r);
		if ($urandom_range(99) < send_idle_pct) begin
			rpt_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		rpt <= r;
		rpt_valid <= 1'b1;
		do @(posedge clk); while (rpt_stall);
	endtask

	task automatic wait_events_drained();
		rpt_valid <= 1'b0;
		@(posedge clk);
		while (key_events_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_expected_function(input logic [31:0] code);
		wait_events_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		@(posedge clk);
		cfg_we <= 1'b0;
		match_function = code;
		cfg_writes++;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		stall_pct <= recv_pct;
	endtask

	task automatic test_directed_reports();
		set_idling(0, 0);
		send_report(make_report(32'd1, 8'h00, 0, 0, 0, 0, 0, 0));
		send_report(make_report(32'd1, 8'hFF, 4, 5, 6, 7, 8, 9));
		send_report(make_report(32'd1, 8'h55, 9, 8, 7, 6, 5, 4));
		send_report(make_report(32'd0, 8'hFF, 10, 11, 12, 13, 14, 15));
		send_report(make_report(32'hFFFF_FFFF, 8'h00, 0, 0, 0, 0, 0, 0));
		send_report(make_report(32'h8000_0001, 8'h0F, 3, 3, 3, 3, 3, 3));
		// unknown ROM entries, none codes mixed in
		send_report(make_report(32'd1, 8'hAA, 255, 130, 3, 1, 2, 153));
		// same key in several slots: one press each
		send_report(make_report(32'd1, 8'h01, 20, 20, 20, 0, 0, 255));
		send_report(make_report(32'd1, 8'h80, 3, 3, 3, 3, 3, 3));
		send_report(make_report(32'd1, 8'h00, 224, 225, 226, 227, 228, 229));
		// all six slots change: 20 events
		send_report(make_report(32'd1, 8'hFF, 250, 251, 252, 253, 254, 255));
		send_report(make_report(32'd1, 8'h0F, 4, 29, 30, 39, 40, 152));
		send_report(make_report(32'd1, 8'hF0, 133, 134, 135, 152, 153, 0));
		wait_events_drained();
	endtask

	task automatic test_function_code_filter();
		set_expected_function(32'hFFFF_FFFF);
		send_report(make_report(32'hFFFF_FFFF, 8'h3C, 44, 45, 46, 47, 48, 49));
		send_report(make_report(32'd1, 8'hC3, 4, 5, 6, 7, 8, 9));
		send_report(make_report(32'h7FFF_FFFF, 8'hC3, 4, 5, 6, 7, 8, 9));
		set_expected_function(32'd0);
		send_report(make_report(32'd0, 8'h81, 44, 0, 46, 100, 48, 49));
		send_report(make_report(32'hFFFF_FFFF, 8'h7E, 0, 0, 0, 0, 0, 0));
		wait_events_drained();
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct,
		input int count, input logic [31:0] code);
		kre_report_t r;
		int sent;
		set_expected_function(code);
		set_idling(send_pct, recv_pct);
		sent = 0;
		while (sent < count) begin
			r = random_report();
			send_report(r);
			if (r.function_code == match_function)
				sent++;
			if ($urandom_range(99) < 3)
				wait_events_drained();
		end
		wait_events_drained();
	endtask

	task automatic test_full_queue_backpressure();
		set_idling(0, 0);
		holds_asked <= holds_asked + 1;
		for (int i = 0; i < 16; i++)
			send_report(random_report());
		wait_events_drained();
	endtask

	task automatic test_drain_between_reports();
		set_idling(34, 34);
		for (int i = 0; i < 4; i++) begin
			send_report(random_report());
			send_report(random_report());
			wait_events_drained();
		end
	endtask

	initial begin
		load_xlat_rom();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_reports();
		test_function_code_filter();
		test_random_traffic(0, 0, 50, 32'd1);
		test_random_traffic(83, 0, 45, $urandom);
		test_random_traffic(0, 83, 45, $urandom);
		test_random_traffic(34, 34, 45, 32'hFFFF_FFFF);
		test_full_queue_backpressure();
		test_drain_between_reports();
		wait_events_drained();
		$display("Ran %0d reports through the diff (%0d filtered out), checked %0d events,",
			reports_taken, reports_dropped, events_checked);
		$display("%0d function code settings, idle/stall mixes and one long receiver hold",
			cfg_writes);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
